[sv/assert_macros.svh]
// assertion macros used by the decoder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define QSPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define QSPD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/qspd_pkg.sv]
// package for the query string pair decoder: character codes, escape phase, hex decode
`default_nettype none
package qspd_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_AND   = 8'h26;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_PCT  = 2'd1,
      ESC_HIGH = 2'd2
   } esc_phase_type;

   // bit 4 set when the byte is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + HEX_TEN;
            hex_value = {1'b0, d[3:0]};
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            hex_value = {1'b0, d[3:0]};
         end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            d = c - CHAR_LOW_A + HEX_TEN;
            hex_value = {1'b0, d[3:0]};
         end else begin
            hex_value = 5'b1_0000;
         end
      end
   endfunction

endpackage
`default_nettype wire

[sv/query_string_pair_decoder_unit.sv]
// query string pair decoder: splits a parameter string into key and value bytes, percent-decoded
//
// One byte of the parameter string is taken per cycle and gives exactly one result item. An
// accepted byte sits in the input register and is decoded against the parse state combinationally.
// It then moves from the input register to the result register, where its result is offered. A
// new byte can be taken in every cycle while the result side keeps up. A stalled result holds the
// input register, and a full input register stalls the input. Throughput is one item per cycle,
// set by the update of the parse state (field, escape phase, high nibble, halt flag) that is made
// as each item moves on. A byte marked last ends the string and returns the parse state to its
// reset values for the next string.
`default_nettype none
`include "assert_macros.svh"
module query_string_pair_decoder_unit
   import qspd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_in_value_field,
   output logic            rsp_key_done,
   output logic            rsp_pair_done,
   output logic            rsp_key_discarded,
   output logic            rsp_final_item
);

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;

   // parse state
   logic          value_mode_ff, value_mode_in;
   esc_phase_type phase_ff, phase_in;
   logic [3:0]    high_nibble_ff, high_nibble_in;
   logic          halted_ff, halted_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          byte_valid_ff, byte_valid_in;
   logic          value_field_ff, value_field_in;
   logic          key_done_ff, key_done_in;
   logic          pair_done_ff, pair_done_in;
   logic          key_disc_ff, key_disc_in;
   logic          final_ff, final_in;

   logic          req_take;
   logic          advance;
   logic [4:0]    hex;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // per-byte decode
   always_comb begin
      hex            = hex_value(in_byte_ff);
      value_mode_in  = value_mode_ff;
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      halted_in      = halted_ff;
      out_byte_in    = 8'd0;
      byte_valid_in  = 1'b0;
      value_field_in = value_mode_ff;
      key_done_in    = 1'b0;
      pair_done_in   = 1'b0;
      key_disc_in    = 1'b0;
      final_in       = in_last_ff;

      if (!value_mode_ff && in_byte_ff == CHAR_EQ) begin
         key_done_in    = 1'b1;
         value_mode_in  = 1'b1;
         phase_in       = ESC_IDLE;
         high_nibble_in = 4'd0;
         halted_in      = 1'b0;
         pair_done_in   = in_last_ff;
      end else if (value_mode_ff && in_byte_ff == CHAR_AND) begin
         pair_done_in   = 1'b1;
         value_mode_in  = 1'b0;
         phase_in       = ESC_IDLE;
         high_nibble_in = 4'd0;
         halted_in      = 1'b0;
      end else begin
         if (!halted_ff) begin
            unique case (phase_ff)
               ESC_PCT: begin
                  if (hex[4]) begin
                     halted_in = 1'b1;
                     phase_in  = ESC_IDLE;
                  end else begin
                     high_nibble_in = hex[3:0];
                     phase_in       = ESC_HIGH;
                  end
               end
               ESC_HIGH: begin
                  if (hex[4]) begin
                     halted_in = 1'b1;
                  end else begin
                     out_byte_in   = {high_nibble_ff, hex[3:0]};
                     byte_valid_in = 1'b1;
                  end
                  phase_in = ESC_IDLE;
               end
               default: begin
                  if (in_byte_ff == CHAR_PCT) begin
                     phase_in = ESC_PCT;
                  end else begin
                     phase_in      = ESC_IDLE;
                     out_byte_in   = in_byte_ff;
                     byte_valid_in = 1'b1;
                  end
               end
            endcase
         end
         if (in_last_ff) begin
            pair_done_in = value_mode_ff;
            key_disc_in  = !value_mode_ff;
         end
      end

      // end of string
      if (in_last_ff) begin
         value_mode_in  = 1'b0;
         phase_in       = ESC_IDLE;
         high_nibble_in = 4'd0;
         halted_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         value_mode_ff  <= 1'b0;
         phase_ff       <= ESC_IDLE;
         high_nibble_ff <= 4'd0;
         halted_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            value_mode_ff  <= value_mode_in;
            phase_ff       <= phase_in;
            high_nibble_ff <= high_nibble_in;
            halted_ff      <= halted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_is_last;
      end
      if (advance) begin
         out_byte_ff    <= out_byte_in;
         byte_valid_ff  <= byte_valid_in;
         value_field_ff <= value_field_in;
         key_done_ff    <= key_done_in;
         pair_done_ff   <= pair_done_in;
         key_disc_ff    <= key_disc_in;
         final_ff       <= final_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_in_value_field = value_field_ff;
   assign rsp_key_done       = key_done_ff;
   assign rsp_pair_done      = pair_done_ff;
   assign rsp_key_discarded  = key_disc_ff;
   assign rsp_final_item     = final_ff;

   `QSPD_ASSERT(a_empty_never_stalls, !in_valid_ff |-> !req_stall, "stall with empty input register")
   `QSPD_ASSERT(a_last_clears_state, advance && in_last_ff |=> !value_mode_ff && phase_ff == ESC_IDLE && !halted_ff, "state not cleared after last item")
   `QSPD_ASSERT(a_delim_no_byte, rsp_valid_ff && (rsp_key_done || rsp_key_discarded) |-> !(rsp_key_done && rsp_byte_valid) && !(rsp_key_discarded && !rsp_final_item), "delimiter or discard flags inconsistent")
   `QSPD_ASSERT(a_discard_in_key, rsp_valid_ff && rsp_key_discarded |-> !rsp_in_value_field && !rsp_pair_done, "key discarded outside a key")
   `QSPD_ASSERT_ALWAYS(a_no_phase_three, phase_ff == ESC_IDLE || phase_ff == ESC_PCT || phase_ff == ESC_HIGH || reset, "escape phase corrupt")

endmodule
`default_nettype wire
